### rtl/sm4_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and round functions of the sm4 block cipher
// no dependencies; imported by the round unit and the top level

package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RndW      = 5;
  localparam int unsigned NumKeyRegs = 4;

  typedef logic [31:0] word_t;

  // configuration register map, index is paddr[3:2]
  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  localparam word_t FK [NumKeyRegs] = '{
    32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC
  };

  localparam int unsigned RotA = 2;
  localparam int unsigned RotB = 10;
  localparam int unsigned RotC = 18;
  localparam int unsigned RotD = 24;
  localparam int unsigned RotK1 = 13;
  localparam int unsigned RotK2 = 23;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // byte-wise s-box substitution
  function automatic word_t tau(word_t v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic word_t data_mix(word_t b);
    return b ^ rotl(b, RotA) ^ rotl(b, RotB) ^ rotl(b, RotC) ^ rotl(b, RotD);
  endfunction

  function automatic word_t key_mix(word_t b);
    return b ^ rotl(b, RotK1) ^ rotl(b, RotK2);
  endfunction

  // ck byte j of round i is (4i+j)*7 mod 256, byte 0 in the top bits
  function automatic word_t ck_word(logic [RndW-1:0] i);
    word_t      w;
    logic [7:0] idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      w   = {w[23:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

endpackage

### rtl/sm4_in_if.sv
`timescale 1ns / 1ps
// input channel of the sm4 block cipher: direction bit and four block words
// no dependencies

interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] block_word0;
  logic [31:0] block_word1;
  logic [31:0] block_word2;
  logic [31:0] block_word3;

  modport source (
    output valid, action, block_word0, block_word1, block_word2, block_word3,
    input  ready
  );
  modport sink (
    input  valid, action, block_word0, block_word1, block_word2, block_word3,
    output ready
  );
endinterface

### rtl/sm4_out_if.sv
`timescale 1ns / 1ps
// output channel of the sm4 block cipher: four result words
// no dependencies

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word0;
  logic [31:0] result_word1;
  logic [31:0] result_word2;
  logic [31:0] result_word3;

  modport source (
    output valid, result_word0, result_word1, result_word2, result_word3,
    input  ready
  );
  modport sink (
    input  valid, result_word0, result_word1, result_word2, result_word3,
    output ready
  );
endinterface

### rtl/sm4_block_cipher.sv
`timescale 1ns / 1ps
// top level of the sm4 block cipher: apb key registers, round key memory,
// sequencer and output register; depends on sm4_pkg, sm4_round and the two channel interfaces

// SM4 encryption and decryption of one 128-bit block per transaction, with the 128-bit key
// held in four apb registers at byte addresses 0, 4, 8 and 12. On acceptance of a block the
// first round key is read from the 32-entry round key memory in the accepting cycle, then the
// single round unit does one round per cycle while the next round key is read. On the last
// round the result is loaded into the output register and the sequencer returns to idle.
// A new block is taken once the previous result sits in the output register, even while it
// still waits there; if that register is still full at the last round, the finished block
// stays in the window register and no block is accepted until the output frees up. After reset,
// and after every key register write, the round keys are expanded again through the same
// round unit and written into the memory; no block is accepted while this runs.
// Decryption reads the round keys in reverse order.

module sm4_block_cipher import sm4_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sm4_in_if.sink      blk_i,
  sm4_out_if.source   res_o
);

  typedef enum logic [4:0] {
    ST_KEYLOAD = 5'b00001,
    ST_EXPAND  = 5'b00010,
    ST_IDLE    = 5'b00100,
    ST_RUN     = 5'b01000,
    ST_FLUSH   = 5'b10000
  } state_e;

  localparam logic [RndW-1:0] LastRnd = RndW'(NumRounds - 1);

  state_e          state_q, state_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  logic [RndW-1:0] rnd_nxt;
  logic            dec_q, dec_d;
  word_t           win_q [4];
  word_t           win_d [4];
  word_t           win_shift [4];
  word_t           key_q [NumKeyRegs];
  word_t           rk_q;
  word_t           rk_sel;
  word_t           next_word;
  word_t           rk_mem [NumRounds];
  logic            rd_en;
  logic [RndW-1:0] rd_addr;
  logic            mem_we;
  logic            cfg_we;
  cfg_reg_e        cfg_idx;
  logic            in_ready;
  logic            accept;
  logic            out_free;
  logic            out_load;
  logic            out_valid_q, out_valid_d;
  word_t           out_q [4];
  word_t           out_d [4];
  logic            last_rnd;
  logic            key_sched;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign prdata  = key_q[cfg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeyRegs; i++) key_q[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY0: key_q[0] <= pwdata;
        REG_KEY1: key_q[1] <= pwdata;
        REG_KEY2: key_q[2] <= pwdata;
        REG_KEY3: key_q[3] <= pwdata;
        default:  ;
      endcase
    end
  end

  // shared round unit
  assign key_sched = (state_q == ST_EXPAND);
  assign rk_sel    = key_sched ? ck_word(cnt_q) : rk_q;

  sm4_round u_round (
    .win_i       (win_q),
    .rk_i        (rk_sel),
    .key_sched_i (key_sched),
    .next_o      (next_word)
  );

  assign win_shift[0] = win_q[1];
  assign win_shift[1] = win_q[2];
  assign win_shift[2] = win_q[3];
  assign win_shift[3] = next_word;

  assign in_ready = (state_q == ST_IDLE) && !cfg_we;
  assign accept   = blk_i.valid && in_ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign last_rnd = (cnt_q == LastRnd);
  assign rnd_nxt  = cnt_q + RndW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    dec_d    = dec_q;
    win_d    = win_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_KEYLOAD: begin
        for (int i = 0; i < 4; i++) win_d[i] = key_q[i] ^ FK[i];
        cnt_d   = '0;
        state_d = ST_EXPAND;
      end
      ST_EXPAND: begin
        mem_we = 1'b1;
        win_d  = win_shift;
        cnt_d  = rnd_nxt;
        if (last_rnd) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          win_d[0] = blk_i.block_word0;
          win_d[1] = blk_i.block_word1;
          win_d[2] = blk_i.block_word2;
          win_d[3] = blk_i.block_word3;
          dec_d    = blk_i.action;
          cnt_d    = '0;
          rd_en    = 1'b1;
          // decryption starts from the last round key
          rd_addr  = blk_i.action ? LastRnd : '0;
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        win_d = win_shift;
        cnt_d = rnd_nxt;
        if (!last_rnd) begin
          rd_en   = 1'b1;
          rd_addr = dec_q ? ~rnd_nxt : rnd_nxt;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_KEYLOAD;
    endcase
    // a key write restarts the expansion
    if (cfg_we) state_d = ST_KEYLOAD;
  end

  // result words in reverse order, from the round unit on the last round, else from win_q
  always_comb begin
    if (state_q == ST_RUN) begin
      for (int i = 0; i < 4; i++) out_d[i] = win_shift[3 - i];
    end else begin
      for (int i = 0; i < 4; i++) out_d[i] = win_q[3 - i];
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_KEYLOAD;
      cnt_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (out_load) out_q <= out_d;
  end

  // round key memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) rk_mem[cnt_q] <= next_word;
    if (rd_en) rk_q <= rk_mem[rd_addr];
  end

  assign blk_i.ready        = in_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.result_word0 = out_q[0];
  assign res_o.result_word1 = out_q[1];
  assign res_o.result_word2 = out_q[2];
  assign res_o.result_word3 = out_q[3];

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_RUN)
    else $error("accepted block did not start its rounds");

  a_expand_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPAND && last_rnd && !cfg_we) |=> state_q == ST_IDLE)
    else $error("key expansion did not finish after the last round key");

  a_result_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q == ST_RUN && cnt_q == LastRnd)
                            || $past(state_q == ST_FLUSH)))
    else $error("result shown without a finished block");

endmodule

### rtl/sm4_round.sv
`timescale 1ns / 1ps
// shared sm4 round unit, used both for the key schedule and for data rounds
// depends on sm4_pkg

module sm4_round import sm4_pkg::*; (
  input  word_t win_i [4],
  input  word_t rk_i,
  input  logic  key_sched_i,
  output word_t next_o
);

  word_t mixed;
  word_t subst;

  assign mixed  = win_i[1] ^ win_i[2] ^ win_i[3] ^ rk_i;
  assign subst  = tau(mixed);
  assign next_o = win_i[0] ^ (key_sched_i ? key_mix(subst) : data_mix(subst));

endmodule
